[sv/eaf_pkg.sv]
// eaf_pkg: shared types and constants for the encoder angle filter
// no dependencies; imported by every module of the block
package eaf_pkg;

	// joint axis codes
	localparam logic [1:0] AXIS_BASE  = 2'd0;
	localparam logic [1:0] AXIS_LOWER = 2'd1;
	localparam logic [1:0] AXIS_UPPER = 2'd2;
	localparam logic [1:0] AXIS_NONE  = 2'd3;

	// window and arithmetic constants
	localparam logic [2:0]         WINDOW_LEN      = 3'd5;
	localparam logic [11:0]        NOISE_LIMIT     = 12'd20;
	localparam logic [11:0]        HALF_COUNTS     = 12'd2048;
	localparam logic [5:0]         UNITS_PER_COUNT = 6'd45;
	localparam logic [15:0]        RECIP3          = 16'd43691;
	localparam int                 RECIP3_SHIFT    = 17;
	localparam logic signed [19:0] FULL_TURN       = 20'sd184320;
	localparam logic [17:0]        BASE_MIN        = 18'd0;
	localparam logic [17:0]        BASE_MAX        = 18'd92160;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_REF_COUNT_X  = 3'd0,
		REG_REF_COUNT_Y  = 3'd1,
		REG_REF_COUNT_Z  = 3'd2,
		REG_REF_ANGLE_X  = 3'd3,
		REG_REF_ANGLE_Y  = 3'd4,
		REG_REF_ANGLE_Z  = 3'd5,
		REG_LOWER_LIMITS = 3'd6,
		REG_UPPER_LIMITS = 3'd7
	} eaf_reg_t;

	// configuration as seen by the back end
	typedef struct packed {
		logic [2:0][11:0] ref_count;
		logic [2:0][17:0] ref_angle;
		logic [35:0]      lower_limits;
		logic [35:0]      upper_limits;
	} eaf_cfg_t;

	// finished window handed from front to back
	typedef struct packed {
		logic [1:0]  axis;
		logic [13:0] trimmed;
	} eaf_win_t;

	// queue status used by the top level and, as head valid, by the back end
	typedef struct packed {
		logic full;
		logic not_empty;
	} eaf_qstat_t;

endpackage

[sv/eaf_window.sv]
// eaf_window: front end, collects five-sample windows per axis and rejects noisy ones
// depends on eaf_pkg
module eaf_window (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         axis,
	input  logic [11:0]        sample,
	output logic               push,
	output eaf_pkg::eaf_win_t  win
);
	import eaf_pkg::*;

	logic [2:0]  fill_q;
	logic [1:0]  axis_q;
	logic [11:0] max_q;
	logic [11:0] min_q;
	logic [14:0] sum_q;

	logic        take;
	logic        restart;
	logic [2:0]  eff_fill;
	logic [11:0] eff_max;
	logic [11:0] eff_min;
	logic [14:0] eff_sum;
	logic [2:0]  new_fill;
	logic [11:0] new_max;
	logic [11:0] new_min;
	logic [14:0] new_sum;
	logic [11:0] spread;
	logic        done;
	logic [14:0] trimmed_full;

	// running window update for the incoming sample
	always_comb begin
		take     = accept && (axis != AXIS_NONE);
		restart  = (fill_q != 3'd0) && (axis != axis_q);
		eff_fill = restart ? 3'd0 : fill_q;
		eff_max  = restart ? 12'd0 : max_q;
		eff_min  = restart ? 12'hFFF : min_q;
		eff_sum  = restart ? 15'd0 : sum_q;
		new_fill = eff_fill + 3'd1;
		new_max  = (sample > eff_max) ? sample : eff_max;
		new_min  = (sample < eff_min) ? sample : eff_min;
		new_sum  = eff_sum + {3'b000, sample};
		spread   = new_max - new_min;
		done     = (new_fill == WINDOW_LEN);
		trimmed_full = new_sum - {3'b000, new_max} - {3'b000, new_min};
		push     = take && done && (spread <= NOISE_LIMIT);
		win.axis    = axis;
		win.trimmed = trimmed_full[13:0];
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 3'd0;
			axis_q <= AXIS_BASE;
			max_q  <= 12'd0;
			min_q  <= 12'hFFF;
			sum_q  <= 15'd0;
		end else if (take) begin
			axis_q <= axis;
			if (done) begin
				fill_q <= 3'd0;
				max_q  <= 12'd0;
				min_q  <= 12'hFFF;
				sum_q  <= 15'd0;
			end else begin
				fill_q <= new_fill;
				max_q  <= new_max;
				min_q  <= new_min;
				sum_q  <= new_sum;
			end
		end
	end

endmodule

[sv/eaf_queue.sv]
// eaf_queue: short first-in first-out queue between window front end and angle back end
// depends on eaf_pkg
module eaf_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  eaf_pkg::eaf_win_t  push_data,
	input  logic               pop,
	output eaf_pkg::eaf_win_t  head,
	output eaf_pkg::eaf_qstat_t stat
);
	import eaf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	eaf_win_t      mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	// status and head of queue
	always_comb begin
		stat.full      = (count_q == FULL_COUNT);
		stat.not_empty = (count_q != '0);
		do_push        = push && !stat.full;
		do_pop         = pop && stat.not_empty;
		head           = mem[rd_ptr_q];
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/eaf_angle.sv]
// eaf_angle: back end, mean of a window to wrapped and clamped joint angle
// depends on eaf_pkg
module eaf_angle (
	input  logic                clk,
	input  logic                arst_n,
	input  eaf_pkg::eaf_cfg_t   cfg,
	input  eaf_pkg::eaf_win_t   head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [17:0]         angle,
	output logic [1:0]          result_axis,
	output logic [11:0]         mean_count
);
	import eaf_pkg::*;

	logic adv;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic [1:0]  axis_s1, axis_s2, axis_s3, axis_s4, axis_s5, axis_q;
	logic [11:0] mean_s1, mean_s2, mean_s3, mean_s4, mean_s5, mean_q;
	logic [11:0] diff_s2;
	logic        pos_s2, pos_s3;
	logic [17:0] prod_s3;
	logic        far_s3, far_s4, far_s5;
	logic signed [19:0] raw_s4;
	logic [17:0] wrap_s5;
	logic        neg_s5;
	logic [17:0] angle_q;

	logic [29:0] recip_prod;
	logic [11:0] rc;
	logic [17:0] mul45;
	logic signed [19:0] base;
	logic signed [19:0] step;
	logic signed [19:0] wrap_val;
	logic [17:0] lo;
	logic [17:0] hi;
	logic [17:0] clamped;

	// whole pipeline moves when the output register is free or being taken
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && head_valid;

	// per-stage arithmetic
	always_comb begin
		// divide by three through the reciprocal
		recip_prod = {16'd0, head.trimmed} * {14'd0, RECIP3};
		// count difference to the reference
		rc = cfg.ref_count[axis_s1];
		// units per count
		mul45 = {6'd0, diff_s2} * {12'd0, UNITS_PER_COUNT};
		// signed raw angle
		base = {2'b00, cfg.ref_angle[axis_s3]};
		step = {2'b00, prod_s3};
		// single wrap into one turn
		if (raw_s4 > FULL_TURN) begin
			wrap_val = raw_s4 - FULL_TURN;
		end else if (raw_s4 < 20'sd0) begin
			wrap_val = raw_s4 + FULL_TURN;
		end else begin
			wrap_val = raw_s4;
		end
		// axis limits
		case (axis_s5)
			AXIS_LOWER: begin
				lo = cfg.lower_limits[17:0];
				hi = cfg.lower_limits[35:18];
			end
			AXIS_UPPER: begin
				lo = cfg.upper_limits[17:0];
				hi = cfg.upper_limits[35:18];
			end
			default: begin
				lo = BASE_MIN;
				hi = BASE_MAX;
			end
		endcase
		// clamp, the far side flips the chosen limit
		if (wrap_s5 >= lo && wrap_s5 <= hi) begin
			clamped = wrap_s5;
		end else if (far_s5) begin
			clamped = neg_s5 ? hi : lo;
		end else begin
			clamped = neg_s5 ? lo : hi;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: mean count
			axis_s1 <= head.axis;
			mean_s1 <= recip_prod[RECIP3_SHIFT +: 12];
			// s2: difference and direction
			axis_s2 <= axis_s1;
			mean_s2 <= mean_s1;
			pos_s2  <= mean_s1 > rc;
			diff_s2 <= (mean_s1 > rc) ? mean_s1 - rc : rc - mean_s1;
			// s3: scaled difference
			axis_s3 <= axis_s2;
			mean_s3 <= mean_s2;
			pos_s3  <= pos_s2;
			prod_s3 <= mul45;
			far_s3  <= diff_s2 > HALF_COUNTS;
			// s4: raw angle
			axis_s4 <= axis_s3;
			mean_s4 <= mean_s3;
			far_s4  <= far_s3;
			raw_s4  <= pos_s3 ? base + step : base - step;
			// s5: wrapped angle
			axis_s5 <= axis_s4;
			mean_s5 <= mean_s4;
			far_s5  <= far_s4;
			neg_s5  <= raw_s4 < 20'sd0;
			wrap_s5 <= wrap_val[17:0];
			// output register
			axis_q  <= axis_s5;
			mean_q  <= mean_s5;
			angle_q <= clamped;
		end
	end

	assign out_valid   = out_valid_q;
	assign angle       = angle_q;
	assign result_axis = axis_q;
	assign mean_count  = mean_q;

endmodule

[sv/encoder_angle_filter.sv]
// encoder_angle_filter: top level, configuration registers, window front end,
// queue and angle back end; depends on eaf_pkg, eaf_window, eaf_queue, eaf_angle
//
//  port group   handshake            payload
//  input        in_valid / in_stall   axis, sample
//  result       out_valid / out_stall angle, result_axis, mean_count
//  config       cfg_write             cfg_index, cfg_data
//
// one sample per cycle is taken while the window queue is not full; a window result
// passes the window queue, back end stages s1 to s5 and the output register.
// the front end stalls only when the window queue is full; the back end
// pipeline holds as a whole while a finished result waits on out_stall.
// reset clears the window, the queue and all pipeline valids, and loads the
// reference and limit registers with their defaults.
module encoder_angle_filter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  axis,
	input  logic [11:0] sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [17:0] angle,
	output logic [1:0]  result_axis,
	output logic [11:0] mean_count,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [35:0] cfg_data
);
	import eaf_pkg::*;

	eaf_cfg_t   cfg_q;
	eaf_win_t   win;
	eaf_win_t   head;
	eaf_qstat_t qstat;
	logic       accept;
	logic       push;
	logic       pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_count[0] <= 12'd95;
			cfg_q.ref_count[1] <= 12'd1429;
			cfg_q.ref_count[2] <= 12'd1998;
			cfg_q.ref_angle[0] <= 18'd46080;
			cfg_q.ref_angle[1] <= 18'd16975;
			cfg_q.ref_angle[2] <= 18'd46198;
			cfg_q.lower_limits <= 36'd24159191040;
			cfg_q.upper_limits <= 36'd24159191040;
		end else if (cfg_write) begin
			unique case (eaf_reg_t'(cfg_index))
				REG_REF_COUNT_X:  cfg_q.ref_count[0] <= cfg_data[11:0];
				REG_REF_COUNT_Y:  cfg_q.ref_count[1] <= cfg_data[11:0];
				REG_REF_COUNT_Z:  cfg_q.ref_count[2] <= cfg_data[11:0];
				REG_REF_ANGLE_X:  cfg_q.ref_angle[0] <= cfg_data[17:0];
				REG_REF_ANGLE_Y:  cfg_q.ref_angle[1] <= cfg_data[17:0];
				REG_REF_ANGLE_Z:  cfg_q.ref_angle[2] <= cfg_data[17:0];
				REG_LOWER_LIMITS: cfg_q.lower_limits <= cfg_data;
				REG_UPPER_LIMITS: cfg_q.upper_limits <= cfg_data;
				default: ;
			endcase
		end
	end

	// input transfer
	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	eaf_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.axis   (axis),
		.sample (sample),
		.push   (push),
		.win    (win)
	);

	eaf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (win),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	eaf_angle u_angle (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.head_valid  (qstat.not_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.angle       (angle),
		.result_axis (result_axis),
		.mean_count  (mean_count)
	);

	// a finished window never arrives at a full queue
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("window pushed into full queue");

	// the back end never pops an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.not_empty)
		else $error("pop from empty queue");

	// results never carry the unused axis code
	a_axis_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_axis != AXIS_NONE))
		else $error("result with unused axis code");

	// base axis results stay inside the fixed base limits
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_axis == AXIS_BASE) |-> (angle <= BASE_MAX))
		else $error("base angle beyond limit");

endmodule
